FILE: rtl/core/bbc_pkg.sv
package bbc_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int PTR_W = $clog2(STACK_DEPTH);
  localparam int NEST_W = 6;
  localparam int BYTE_W = 8;

  typedef logic [PTR_W-1:0] ptr_t;

  localparam ptr_t DEPTH_MAX = PTR_W'(STACK_DEPTH - 1);

  localparam logic [BYTE_W-1:0] CHAR_NUL = 8'h00;
  localparam logic [BYTE_W-1:0] CHAR_QUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CHAR_LSQUARE = 8'h5B;
  localparam logic [BYTE_W-1:0] CHAR_RSQUARE = 8'h5D;
  localparam logic [BYTE_W-1:0] CHAR_LCURLY = 8'h7B;
  localparam logic [BYTE_W-1:0] CHAR_RCURLY = 8'h7D;

  localparam logic KIND_CURLY = 1'b0;
  localparam logic KIND_SQUARE = 1'b1;

  typedef enum logic [1:0] {
    ST_RUNNING = 2'd0,
    ST_PASS    = 2'd1,
    ST_FAIL    = 2'd2
  } status_t;

  typedef struct packed {
    status_t            status;
    logic [NEST_W-1:0]  nesting_depth;
  } result_t;

  function automatic logic [NEST_W-1:0] to_nest(ptr_t p);
    logic [NEST_W+PTR_W-1:0] w;
    w = {{NEST_W{1'b0}}, p};
    return w[NEST_W-1:0];
  endfunction

endpackage

FILE: rtl/core/bbc_if.sv
interface bbc_text_if;
  import bbc_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              last;
  modport source (output valid, output text_byte, output last, input ready);
  modport sink (input valid, input text_byte, input last, output ready);
endinterface

interface bbc_verdict_if;
  import bbc_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [NEST_W-1:0] nesting_depth;
  modport source (output valid, output status, output nesting_depth, input ready);
  modport sink (input valid, input status, input nesting_depth, output ready);
endinterface

FILE: rtl/core/bbc_ram.sv
module bbc_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 1,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/bbc_stack_ctrl.sv
module bbc_stack_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     xfer,
  input  logic [bbc_pkg::BYTE_W-1:0] text_byte,
  input  logic                     last,
  output bbc_pkg::result_t         result
);
  import bbc_pkg::*;

  // The top entry of the stack lives in top_kind; the memory holds the entries
  // below it, and the entry under the top is always prefetched.
  ptr_t depth;
  ptr_t depth_next;
  ptr_t depth_exam;
  logic top_kind;
  logic top_kind_next;
  logic top_exam;
  logic inside_quotes;
  logic inside_quotes_next;
  logic quote_exam;
  logic failed;
  logic failed_next;
  logic failed_exam;
  logic fwd_hit;
  logic fwd_hit_next;
  logic fwd_kind;

  logic want_push;
  logic want_pop;
  logic op_kind;
  logic do_push;
  logic do_pop;
  logic bad_op;
  logic ends;
  logic below_kind;
  logic ram_kind;
  logic wr_en;
  ptr_t wr_addr;
  ptr_t rd_addr;

  bbc_ram #(.DEPTH(STACK_DEPTH), .WIDTH(1)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (top_kind),
    .rd_addr (rd_addr),
    .rd_data (ram_kind)
  );

  assign below_kind = fwd_hit ? fwd_kind : ram_kind;

  always_comb begin
    want_push = 1'b0;
    want_pop = 1'b0;
    op_kind = KIND_CURLY;
    quote_exam = inside_quotes;
    if (!failed && text_byte != CHAR_NUL) begin
      if (inside_quotes) begin
        if (text_byte == CHAR_QUOTE) begin
          quote_exam = 1'b0;
        end
      end else begin
        case (text_byte)
          CHAR_LCURLY: begin
            want_push = 1'b1;
            op_kind = KIND_CURLY;
          end
          CHAR_LSQUARE: begin
            want_push = 1'b1;
            op_kind = KIND_SQUARE;
          end
          CHAR_RCURLY: begin
            want_pop = 1'b1;
            op_kind = KIND_CURLY;
          end
          CHAR_RSQUARE: begin
            want_pop = 1'b1;
            op_kind = KIND_SQUARE;
          end
          CHAR_QUOTE: begin
            quote_exam = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end

    do_push = want_push && (depth != DEPTH_MAX);
    do_pop = want_pop && (depth != '0) && (top_kind == op_kind);
    bad_op = (want_push && !do_push) || (want_pop && !do_pop);

    if (do_push) begin
      depth_exam = depth + PTR_W'(1);
      top_exam = op_kind;
    end else if (do_pop) begin
      depth_exam = depth - PTR_W'(1);
      top_exam = below_kind;
    end else begin
      depth_exam = depth;
      top_exam = top_kind;
    end
    failed_exam = failed || bad_op;

    ends = last || (text_byte == CHAR_NUL);
    result.nesting_depth = to_nest(depth_exam);
    if (!ends) begin
      result.status = ST_RUNNING;
    end else if (!failed_exam && depth_exam == '0) begin
      result.status = ST_PASS;
    end else begin
      result.status = ST_FAIL;
    end

    if (!xfer) begin
      depth_next = depth;
      top_kind_next = top_kind;
      inside_quotes_next = inside_quotes;
      failed_next = failed;
    end else if (ends) begin
      depth_next = '0;
      top_kind_next = top_exam;
      inside_quotes_next = 1'b0;
      failed_next = 1'b0;
    end else begin
      depth_next = depth_exam;
      top_kind_next = top_exam;
      inside_quotes_next = quote_exam;
      failed_next = failed_exam;
    end

    wr_en = xfer && do_push && (depth != '0);
    wr_addr = depth - PTR_W'(1);
    rd_addr = depth_next - PTR_W'(2);
    fwd_hit_next = wr_en && (wr_addr == rd_addr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
      inside_quotes <= 1'b0;
      failed <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      depth <= depth_next;
      inside_quotes <= inside_quotes_next;
      failed <= failed_next;
      fwd_hit <= fwd_hit_next;
    end
  end

  always_ff @(posedge clk) begin
    top_kind <= top_kind_next;
    fwd_kind <= top_kind;
  end

endmodule

FILE: rtl/core/bbc_out_buf.sv
module bbc_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bbc_pkg::result_t din,
  output logic             can_accept,
  output logic             valid,
  input  logic             take,
  output bbc_pkg::result_t dout
);
  import bbc_pkg::*;

  result_t    ent [2];
  logic [1:0] count;
  logic [1:0] count_next;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       pop;

  assign can_accept = (count != 2'd2);
  assign valid = (count != 2'd0);
  assign dout = ent[rd_ptr];
  assign pop = valid && take;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= din;
    end
  end

endmodule

FILE: rtl/core/bracket_balance_checker_unit.sv
// Checks that curly and square brackets in a byte stream nest and match, skipping
// text between double quotes, and gives one result per byte: the nesting depth after
// that byte and, on the byte that ends the string (last set or a zero byte), the
// verdict. The unit takes one byte every cycle while the output queue has room, and
// the result of a byte can be taken in the cycle after its transfer. The stack sits
// in a one-port-write, one-port-read memory; the top entry is held in a register and
// the entry under it is read ahead every cycle, with forwarding when a push writes
// the entry being read, so a push or pop of any kind never stalls the input. A
// two-entry output queue lets the input keep flowing while a result waits to be taken.
module bracket_balance_checker_unit (
  input  logic          clk,
  input  logic          rst,
  bbc_text_if.sink      text_in,
  bbc_verdict_if.source verdict_out
);
  import bbc_pkg::*;

  logic    xfer;
  logic    can_accept;
  result_t result;
  result_t held;

  assign text_in.ready = can_accept;
  assign xfer = text_in.valid && can_accept;

  bbc_stack_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .xfer      (xfer),
    .text_byte (text_in.text_byte),
    .last      (text_in.last),
    .result    (result)
  );

  bbc_out_buf u_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (xfer),
    .din        (result),
    .can_accept (can_accept),
    .valid      (verdict_out.valid),
    .take       (verdict_out.ready),
    .dout       (held)
  );

  assign verdict_out.status = held.status;
  assign verdict_out.nesting_depth = held.nesting_depth;

endmodule

FILE: rtl/core/bbc_checker.sv
module bbc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [1:0]                 status,
  input logic [bbc_pkg::NEST_W-1:0] nesting_depth
);
  import bbc_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_xfer_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("no result pending after an input transfer");

  a_pass_depth: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_PASS) |-> nesting_depth == '0)
    else $error("balanced verdict with open brackets");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(nesting_depth)))
    else $error("stalled result changed");

endmodule

bind bracket_balance_checker_unit bbc_checker u_bbc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (text_in.valid),
  .in_ready      (text_in.ready),
  .out_valid     (verdict_out.valid),
  .out_ready     (verdict_out.ready),
  .status        (verdict_out.status),
  .nesting_depth (verdict_out.nesting_depth)
);
